[hdl/sha1_pkg.sv]
// SHA-1 engine package: round constants, initial chaining values,
// sequencer state encoding and sizing constants. No dependencies.
package sha1_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumChain = 5;
  localparam int unsigned NumSched = 16;
  localparam int unsigned NumRound = 80;
  localparam int unsigned LenW     = 64;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [NumChain-1:0][WordW-1:0] InitChain = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] PosLenStart = 6'd55; // byte before the length field
  localparam logic [5:0] PosLast     = 6'd63;
  localparam logic [6:0] RoundLast   = 7'(NumRound - 1);
  localparam logic [2:0] OutLast     = 3'(NumChain - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MARK  = 7'b0000010,
    ST_ZERO  = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_CHAIN = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

endpackage

[hdl/sha1_hash_engine_unit.sv]
// SHA-1 engine top level: byte gathering, padding sequencer, one shared
// round unit and digest output. Depends on sha1_pkg.
//
// Takes one byte word per cycle while a block is being gathered. Every 64th
// byte is followed by a stall with s_axis_tready_o low: 80 rounds through the
// single round adder, then an add into the chaining words. A word with tlast
// starts padding, fed one byte per cycle except during the rounds of each
// completed block; after padding the five digest words H0..H4 leave
// on the master side, H4 with tlast; the next message starts afterwards.
module sha1_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tuser_i,  // [0] byte_present
  input  logic        s_axis_tlast_i,  // last_item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] digest_word
  output logic        m_axis_tlast_o   // digest_last
);
  import sha1_pkg::*;

  state_e state_q, state_d, ret_q, ret_d;
  logic [NumChain-1:0][WordW-1:0] chain_q, chain_d;
  logic [WordW-1:0] sched_q [NumSched];
  logic [WordW-1:0] wv_q [NumChain];
  logic [LenW-1:0]  bitlen_q, bitlen_d;
  logic [5:0]       pos_q, pos_d;
  logic [6:0]       rnd_q, rnd_d;
  logic [2:0]       out_idx_q, out_idx_d;

  logic             absorb_en;
  logic [7:0]       absorb_byte;
  logic             load_wv;
  logic             round_en;
  logic [WordW-1:0] w_t, f_t, k_t, t_t, w_mix;
  logic             in_acc;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // round unit
  always_comb begin
    w_mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
    w_t   = (rnd_q < 7'd16) ? sched_q[0] : {w_mix[30:0], w_mix[31]};
    case (rnd_q) inside
      [7'd0:7'd19]: begin
        f_t = (wv_q[1] & wv_q[2]) | (~wv_q[1] & wv_q[3]);
        k_t = K0;
      end
      [7'd20:7'd39]: begin
        f_t = wv_q[1] ^ wv_q[2] ^ wv_q[3];
        k_t = K1;
      end
      [7'd40:7'd59]: begin
        f_t = (wv_q[1] & wv_q[2]) | (wv_q[1] & wv_q[3]) | (wv_q[2] & wv_q[3]);
        k_t = K2;
      end
      default: begin
        f_t = wv_q[1] ^ wv_q[2] ^ wv_q[3];
        k_t = K3;
      end
    endcase
    t_t = {wv_q[0][26:0], wv_q[0][31:27]} + f_t + wv_q[4] + k_t + w_t;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    chain_d     = chain_q;
    bitlen_d    = bitlen_q;
    pos_d       = pos_q;
    rnd_d       = rnd_q;
    out_idx_d   = out_idx_q;
    absorb_en   = 1'b0;
    absorb_byte = s_axis_tdata_i;
    round_en    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            absorb_en = 1'b1;
            bitlen_d  = bitlen_q + LenW'(8);
          end
          if (s_axis_tuser_i && pos_q == PosLast) begin
            state_d = ST_ROUND;
            ret_d   = s_axis_tlast_i ? ST_MARK : ST_IDLE;
          end else if (s_axis_tlast_i) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        absorb_en   = 1'b1;
        absorb_byte = PadMarker;
        if (pos_q == PosLast) begin
          state_d = ST_ROUND;
          ret_d   = ST_ZERO;
        end else if (pos_q == PosLenStart) begin
          state_d = ST_LEN;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        absorb_en   = 1'b1;
        absorb_byte = 8'h00;
        if (pos_q == PosLast) begin
          state_d = ST_ROUND;
          ret_d   = ST_ZERO;
        end else if (pos_q == PosLenStart) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        absorb_en   = 1'b1;
        absorb_byte = bitlen_q[{~pos_q[2:0], 3'b000} +: 8];
        if (pos_q == PosLast) begin
          state_d = ST_ROUND;
          ret_d   = ST_OUT;
        end
      end
      ST_ROUND: begin
        round_en = 1'b1;
        if (rnd_q == RoundLast) begin
          rnd_d   = '0;
          state_d = ST_CHAIN;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      ST_CHAIN: begin
        for (int i = 0; i < NumChain; i++) begin
          chain_d[i] = chain_q[i] + wv_q[i];
        end
        state_d = ret_q;
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          if (out_idx_q == OutLast) begin
            out_idx_d = '0;
            chain_d   = InitChain;
            bitlen_d  = '0;
            state_d   = ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (absorb_en) begin
      pos_d = pos_q + 6'd1;
    end
  end

  assign load_wv        = absorb_en && (pos_q == PosLast);
  assign m_axis_tdata_o = chain_q[out_idx_q];
  assign m_axis_tlast_o = (out_idx_q == OutLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      chain_q   <= InitChain;
      bitlen_q  <= '0;
      pos_q     <= '0;
      rnd_q     <= '0;
      out_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      chain_q   <= chain_d;
      bitlen_q  <= bitlen_d;
      pos_q     <= pos_d;
      rnd_q     <= rnd_d;
      out_idx_q <= out_idx_d;
    end
  end

  // block buffer doubles as the message schedule window
  always_ff @(posedge clk_i) begin
    if (absorb_en) begin
      for (int i = 0; i < NumSched - 1; i++) begin
        sched_q[i] <= {sched_q[i][23:0], sched_q[i+1][31:24]};
      end
      sched_q[NumSched-1] <= {sched_q[NumSched-1][23:0], absorb_byte};
    end else if (round_en) begin
      for (int i = 0; i < NumSched - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[NumSched-1] <= w_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wv) begin
      for (int i = 0; i < NumChain; i++) begin
        wv_q[i] <= chain_q[i];
      end
    end else if (round_en) begin
      wv_q[4] <= wv_q[3];
      wv_q[3] <= wv_q[2];
      wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t_t;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while digest pending");

  a_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == RoundLast) |=> (state_q == ST_CHAIN))
    else $error("round count overran");

  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> (rnd_q == '0))
    else $error("round counter not cleared");

  a_out_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (pos_q == '0))
    else $error("digest out with partial block");

  a_out_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_idx_q != '0) |-> ((out_idx_q <= OutLast) && (state_q == ST_OUT)))
    else $error("digest index out of range");

endmodule
